// ===== rtl/sfs_pkg.sv =====
// Shared types and constants for the nearest-first stop scheduler.
// Used by sfs_cell and nearest_first_stop_scheduler_top; no dependencies.
package sfs_pkg;

    // Default sizing
    localparam int MAX_TARGETS_DEF = 16;
    localparam int FLOOR_BITS_DEF  = 16;

    // Fixed widths of ports and registers
    localparam int EXT_FLOOR_W = 16;
    localparam int TIME_W      = 32;
    localparam int RATE_W      = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int OP_W        = 2;

    localparam logic [RATE_W-1:0] TIME_PER_FLOOR_RESET = 8'd10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_FLOOR    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_PER_FLOOR = 1'b1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
    localparam logic [OP_W-1:0] OP_ARRIVAL = 2'd1;
    localparam logic [OP_W-1:0] OP_NEAREST = 2'd2;

    // Per-cycle command to the row of target cells
    typedef enum logic [1:0] {
        CM_HOLD   = 2'd0,
        CM_ROTATE = 2'd1,
        CM_REMOVE = 2'd2,
        CM_APPEND = 2'd3
    } cell_mode_t;

endpackage

// ===== rtl/sfs_cell.sv =====
// One slot of the target list chain.
// Depends on sfs_pkg (cell_mode_t).
module sfs_cell #(
    parameter int FLOOR_BITS = sfs_pkg::FLOOR_BITS_DEF,
    parameter int IDX_W      = 4,
    parameter int INDEX      = 0
) (
    input  logic                         clk,
    input  sfs_pkg::cell_mode_t          mode,
    input  logic [IDX_W-1:0]             sel,
    input  logic signed [FLOOR_BITS-1:0] wr_data,
    input  logic signed [FLOOR_BITS-1:0] nbr_data,
    output logic signed [FLOOR_BITS-1:0] data
);

    logic signed [FLOOR_BITS-1:0] data_reg;
    logic signed [FLOOR_BITS-1:0] data_next;

    // Rotate or compact take the neighbor's value; append loads the new target
    always_comb
    begin
        data_next = data_reg;
        case (mode)
            sfs_pkg::CM_ROTATE: data_next = nbr_data;
            sfs_pkg::CM_REMOVE:
            begin
                if (sel <= IDX_W'(INDEX))
                    data_next = nbr_data;
            end
            sfs_pkg::CM_APPEND:
            begin
                if (sel == IDX_W'(INDEX))
                    data_next = wr_data;
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== rtl/nearest_first_stop_scheduler_top.sv =====
// Nearest-first stop scheduler: control, travel time and the row of target cells.
// Depends on sfs_pkg and sfs_cell.
// Add: taken, no result. Visit with an empty list: 1 result.
// Arrival-order visit: each stop compacts the chain, then issues.
// Nearest-first visit: each stop takes one full rotation of the cell chain past the
// distance comparator, then compacts the chain and issues. One item at a time.
// Reset (async, active low): floor 0, time 0, empty list, rate 10, flag clear.
module nearest_first_stop_scheduler_top #(
    parameter int MAX_TARGETS = sfs_pkg::MAX_TARGETS_DEF,
    parameter int FLOOR_BITS  = sfs_pkg::FLOOR_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [sfs_pkg::OP_W-1:0]                operation,
    input  logic signed [sfs_pkg::EXT_FLOOR_W-1:0]  target_floor,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [sfs_pkg::EXT_FLOOR_W-1:0]  stop_floor,
    output logic                                    moved,
    output logic [sfs_pkg::TIME_W-1:0]              total_time,
    output logic                                    overflow_seen,
    output logic                                    last,
    input  logic                                    cfg_we,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [sfs_pkg::CFG_DATA_W-1:0]          cfg_data
);

    localparam int IDX_W  = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int CNT_W  = $clog2(MAX_TARGETS + 1);
    localparam int PROD_W = FLOOR_BITS + sfs_pkg::RATE_W;
    localparam int SUM_W  = ((PROD_W > sfs_pkg::TIME_W) ? PROD_W : sfs_pkg::TIME_W) + 1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_REMOVE = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    typedef logic signed [FLOOR_BITS-1:0] floor_t;

    // Control state
    state_t                       state_reg, state_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic                         ovf_reg, ovf_next;
    logic                         nearest_reg, nearest_next;
    logic [IDX_W-1:0]             step_reg, step_next;
    logic                         out_valid_reg, out_valid_next;
    floor_t                       cur_reg, cur_next;
    logic [sfs_pkg::RATE_W-1:0]   tpf_reg, tpf_next;
    logic [sfs_pkg::TIME_W-1:0]   total_reg, total_next;

    // Working and result payload
    logic [IDX_W-1:0]             best_idx_reg, best_idx_next;
    logic [FLOOR_BITS-1:0]        best_dist_reg, best_dist_next;
    floor_t                       best_floor_reg, best_floor_next;
    logic [PROD_W-1:0]            prod_reg, prod_next;
    logic                         mv_pend_reg, mv_pend_next;
    logic signed [sfs_pkg::EXT_FLOOR_W-1:0] stop_reg, stop_next;
    logic                         moved_reg, moved_next;
    logic [sfs_pkg::TIME_W-1:0]   tout_reg, tout_next;
    logic                         ovf_out_reg, ovf_out_next;
    logic                         last_reg, last_next;

    // Cell chain
    sfs_pkg::cell_mode_t          cell_mode;
    logic [IDX_W-1:0]             cell_sel;
    floor_t                       cell_data [MAX_TARGETS];
    floor_t                       in_floor;
    floor_t                       head;

    logic                         acc_in;
    logic                         emit_ok;
    logic                         head_valid;
    logic [FLOOR_BITS-1:0]        head_dist;
    logic [FLOOR_BITS-1:0]        best_fdist;
    logic [SUM_W-1:0]             sum;
    logic [sfs_pkg::TIME_W-1:0]   total_sat;

    function automatic logic [FLOOR_BITS-1:0] floor_dist(input floor_t a, input floor_t b);
        logic signed [FLOOR_BITS:0] d;
        d = {a[FLOOR_BITS-1], a} - {b[FLOOR_BITS-1], b};
        if (d[FLOOR_BITS])
            d = -d;
        return d[FLOOR_BITS-1:0];
    endfunction

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TARGETS; gi++)
        begin : g_cell
            localparam int NXT = (gi + 1) % MAX_TARGETS;
            sfs_cell #(
                .FLOOR_BITS (FLOOR_BITS),
                .IDX_W      (IDX_W),
                .INDEX      (gi)
            ) u_cell (
                .clk      (clk),
                .mode     (cell_mode),
                .sel      (cell_sel),
                .wr_data  (in_floor),
                .nbr_data (cell_data[NXT]),
                .data     (cell_data[gi])
            );
        end
    endgenerate

    assign head       = cell_data[0];
    assign in_floor   = FLOOR_BITS'(target_floor);
    assign in_ready   = (state_reg == ST_IDLE);
    assign acc_in     = in_valid && in_ready;
    assign emit_ok    = !out_valid_reg || out_ready;
    assign head_valid = CNT_W'(step_reg) < count_reg;
    assign head_dist  = floor_dist(head, cur_reg);
    assign best_fdist = floor_dist(best_floor_reg, cur_reg);

    // Saturating travel time update
    assign sum       = SUM_W'(total_reg) + SUM_W'(prod_reg);
    assign total_sat = (sum > SUM_W'({sfs_pkg::TIME_W{1'b1}})) ? '1 : sum[sfs_pkg::TIME_W-1:0];

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        nearest_next    = nearest_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg;
        cur_next        = cur_reg;
        tpf_next        = tpf_reg;
        total_next      = total_reg;
        best_idx_next   = best_idx_reg;
        best_dist_next  = best_dist_reg;
        best_floor_next = best_floor_reg;
        prod_next       = prod_reg;
        mv_pend_next    = mv_pend_reg;
        stop_next       = stop_reg;
        moved_next      = moved_reg;
        tout_next       = tout_reg;
        ovf_out_next    = ovf_out_reg;
        last_next       = last_reg;
        cell_mode       = sfs_pkg::CM_HOLD;
        cell_sel        = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (acc_in)
                begin
                    case (operation)
                        sfs_pkg::OP_ADD:
                        begin
                            if (count_reg < CNT_W'(MAX_TARGETS))
                            begin
                                cell_mode  = sfs_pkg::CM_APPEND;
                                cell_sel   = count_reg[IDX_W-1:0];
                                count_next = count_reg + 1'b1;
                            end
                            else
                                ovf_next = 1'b1;
                        end
                        sfs_pkg::OP_ARRIVAL, sfs_pkg::OP_NEAREST:
                        begin
                            nearest_next = (operation == sfs_pkg::OP_NEAREST);
                            if (count_reg == '0)
                            begin
                                // empty list: report current floor, no move
                                best_floor_next = cur_reg;
                                prod_next       = '0;
                                mv_pend_next    = 1'b0;
                                state_next      = ST_EMIT;
                            end
                            else if (operation == sfs_pkg::OP_NEAREST)
                            begin
                                step_next  = '0;
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                best_floor_next = head;
                                best_idx_next   = '0;
                                state_next      = ST_REMOVE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                // one full rotation; strict compare keeps the earliest on a tie
                cell_mode = sfs_pkg::CM_ROTATE;
                if (head_valid && (step_reg == '0 || head_dist < best_dist_reg))
                begin
                    best_dist_next  = head_dist;
                    best_idx_next   = step_reg;
                    best_floor_next = head;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == IDX_W'(MAX_TARGETS - 1))
                    state_next = ST_REMOVE;
            end
            ST_REMOVE:
            begin
                cell_mode    = sfs_pkg::CM_REMOVE;
                cell_sel     = best_idx_reg;
                count_next   = count_reg - 1'b1;
                prod_next    = PROD_W'(best_fdist) * PROD_W'(tpf_reg);
                mv_pend_next = (best_floor_reg != cur_reg);
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    stop_next      = sfs_pkg::EXT_FLOOR_W'(best_floor_reg);
                    moved_next     = mv_pend_reg;
                    ovf_out_next   = ovf_reg;
                    last_next      = (count_reg == '0);
                    if (mv_pend_reg)
                    begin
                        cur_next   = best_floor_reg;
                        total_next = total_sat;
                        tout_next  = total_sat;
                    end
                    else
                        tout_next = total_reg;
                    if (count_reg == '0)
                        state_next = ST_IDLE;
                    else if (nearest_reg)
                    begin
                        step_next  = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        best_floor_next = head;
                        best_idx_next   = '0;
                        state_next      = ST_REMOVE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // Configuration writes
        if (cfg_we)
        begin
            case (cfg_index)
                sfs_pkg::CFG_START_FLOOR:
                begin
                    cur_next   = FLOOR_BITS'($signed(cfg_data[sfs_pkg::EXT_FLOOR_W-1:0]));
                    total_next = '0;
                    count_next = '0;
                end
                sfs_pkg::CFG_TIME_PER_FLOOR: tpf_next = cfg_data[sfs_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            nearest_reg   <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            cur_reg       <= '0;
            tpf_reg       <= sfs_pkg::TIME_PER_FLOOR_RESET;
            total_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            nearest_reg   <= nearest_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            cur_reg       <= cur_next;
            tpf_reg       <= tpf_next;
            total_reg     <= total_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        best_idx_reg   <= best_idx_next;
        best_dist_reg  <= best_dist_next;
        best_floor_reg <= best_floor_next;
        prod_reg       <= prod_next;
        mv_pend_reg    <= mv_pend_next;
        stop_reg       <= stop_next;
        moved_reg      <= moved_next;
        tout_reg       <= tout_next;
        ovf_out_reg    <= ovf_out_next;
        last_reg       <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign stop_floor    = stop_reg;
    assign moved         = moved_reg;
    assign total_time    = tout_reg;
    assign overflow_seen = ovf_out_reg;
    assign last          = last_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TARGETS))
        else $error("target count beyond capacity");

    a_empty_visit: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_in && count_reg == '0 && !cfg_we &&
         (operation == sfs_pkg::OP_ARRIVAL || operation == sfs_pkg::OP_NEAREST))
        |=> state_reg == ST_EMIT)
        else $error("empty visit did not go to issue");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && emit_ok && count_reg == '0) |=> state_reg == ST_IDLE)
        else $error("final stop did not return to idle");

    a_time_grows: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> total_reg >= $past(total_reg))
        else $error("travel time decreased without a configuration write");

    a_busy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_REMOVE) |-> count_reg != '0)
        else $error("visit step running on an empty list");
`endif

endmodule
